### sv/igl_pkg.sv
// ---------------------------------------------------------------------------
// igl_pkg: shared types for the integer gcd / lcm core
// Controller states, result select codes and the command / status structs
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package igl_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned RES_W  = 63;
  localparam int unsigned SHF_W  = 5;   // shift count for the common power of two

  // Opcodes
  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_FIN,
    ST_DINIT,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  // Source of the result register
  typedef enum logic [1:0] {
    SEL_OR,     // one magnitude is zero: the other one
    SEL_ZERO,   // lcm with a zero operand
    SEL_G,      // computed gcd
    SEL_PROD    // lcm product
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     gcd_step;
    logic     gcd_finish;
    logic     div_init;
    logic     div_step;
    logic     mul;
    logic     write_res;
    res_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic a_zero;
    logic b_zero;
    logic uv_eq;
    logic div_last;
  } sts_t;

endpackage

### sv/igl_datapath.sv
// ---------------------------------------------------------------------------
// igl_datapath: operand, gcd, divider and multiplier registers
// Binary gcd one step per cycle, restoring divider one quotient bit per
// cycle, one 32x32 multiply, and the result register.
// ---------------------------------------------------------------------------
module igl_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  igl_pkg::cmd_t                   cmd_i,
  output igl_pkg::sts_t                   sts_o,
  input  logic                            opcode_i,
  input  logic signed [igl_pkg::WORD_W-1:0] operand_a_i,
  input  logic signed [igl_pkg::WORD_W-1:0] operand_b_i,
  output logic        [igl_pkg::RES_W-1:0]  result_o
);
  import igl_pkg::*;

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    magnitude = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic                  op_q;
  logic [WORD_W-1:0]     ma_q, mb_q;
  logic [WORD_W-1:0]     u_q, v_q, g_q;
  logic [SHF_W-1:0]      k_q;
  logic [WORD_W-1:0]     rem_q, quo_q;
  logic [SHF_W-1:0]      cnt_q;
  logic [2*WORD_W-1:0]   prod_q;
  logic [RES_W-1:0]      res_q;

  logic [WORD_W:0]       div_shift;
  logic [WORD_W:0]       div_diff;
  logic [WORD_W-1:0]     u_minus_v, v_minus_u;

  assign u_minus_v = u_q - v_q;
  assign v_minus_u = v_q - u_q;
  assign div_shift = {rem_q, quo_q[WORD_W-1]};
  assign div_diff  = div_shift - {1'b0, g_q};

  // Operand load and binary gcd steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      ma_q <= magnitude(operand_a_i);
      mb_q <= magnitude(operand_b_i);
      u_q  <= magnitude(operand_a_i);
      v_q  <= magnitude(operand_b_i);
      k_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q > v_q) begin
        u_q <= u_minus_v >> 1;
      end else begin
        v_q <= v_minus_u >> 1;
      end
    end
    if (cmd_i.gcd_finish) begin
      g_q <= u_q << k_q;
    end
  end

  // Restoring divider: ma / g
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= ma_q;
      cnt_q <= '1;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
      if (!div_diff[WORD_W]) begin
        rem_q <= div_diff[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q <= div_shift[WORD_W-1:0];
        quo_q <= {quo_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  // Multiply and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{WORD_W{1'b0}}, quo_q} * {{WORD_W{1'b0}}, mb_q};
    end
    if (cmd_i.write_res) begin
      case (cmd_i.sel)
        SEL_OR:   res_q <= {{(RES_W-WORD_W){1'b0}}, ma_q | mb_q};
        SEL_ZERO: res_q <= '0;
        SEL_G:    res_q <= {{(RES_W-WORD_W){1'b0}}, g_q};
        SEL_PROD: res_q <= prod_q[RES_W-1:0];
        default:  res_q <= '0;
      endcase
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.a_zero   = (ma_q == '0);
  assign sts_o.b_zero   = (mb_q == '0);
  assign sts_o.uv_eq    = (u_q == v_q);
  assign sts_o.div_last = (cnt_q == '0);
  assign result_o       = res_q;

  // A gcd step keeps both values nonzero
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |=> (u_q != '0 && v_q != '0))
    else $error("gcd step produced a zero value");

  // A gcd step never grows either value
  a_gcd_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |=> (u_q <= $past(u_q) && v_q <= $past(v_q)))
    else $error("gcd step grew a value");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < g_q))
    else $error("divider remainder not below divisor");

endmodule

### sv/igl_ctrl.sv
// ---------------------------------------------------------------------------
// igl_ctrl: sequencing state machine for the gcd / lcm core
// Steps each item through load, zero check, gcd loop and, for lcm, divide and multiply,
// and owns the input ready and the output valid.
// ---------------------------------------------------------------------------
module igl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  igl_pkg::sts_t sts_i,
  output igl_pkg::cmd_t cmd_o
);
  import igl_pkg::*;

  state_e   state_q, state_d;
  res_sel_e sel_q, sel_d;
  logic     out_valid_q, out_valid_d;

  // State, select and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.a_zero || sts_i.b_zero) begin
          sel_d   = (sts_i.op == OP_LCM) ? SEL_ZERO : SEL_OR;
          state_d = ST_OUT;
        end else begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.uv_eq) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.gcd_finish = 1'b1;
        if (sts_i.op == OP_LCM) begin
          state_d = ST_DINIT;
        end else begin
          sel_d   = SEL_G;
          state_d = ST_OUT;
        end
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        sel_d     = SEL_PROD;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.write_res = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on result write, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is written only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$past(cmd_o.write_res))
    else $error("result register overwritten while held");

  // The gcd loop is entered only with two nonzero magnitudes
  a_gcd_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && state_d == ST_GCD) |-> (!sts_i.a_zero && !sts_i.b_zero))
    else $error("gcd loop entered with a zero operand");

  // Division is only reached for lcm items
  a_div_lcm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DINIT) |-> (sts_i.op == OP_LCM))
    else $error("divider started for a gcd item");

endmodule

### sv/integer_gcd_lcm_core.sv
// Sequence: after accept, a zero check; if an operand is zero the result is written
// directly. Otherwise binary gcd steps run, one per cycle, until the two values match,
// then the gcd is finished. Lcm adds divider init, 32 quotient bits, one multiply.
// Throughput: one item at a time; the next item is accepted the cycle after the
// result is written, while that result may still wait in the output register.
// Reset (async, active low) clears the controller state and the output valid.
// ---------------------------------------------------------------------------
// integer_gcd_lcm_core: gcd / lcm of two signed 32-bit operand magnitudes
// Controller state machine plus datapath, valid/ready on both sides.
// ---------------------------------------------------------------------------
module integer_gcd_lcm_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic signed [igl_pkg::WORD_W-1:0] operand_a_i,
  input  logic signed [igl_pkg::WORD_W-1:0] operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [igl_pkg::RES_W-1:0]  result_o
);
  import igl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  igl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic
  igl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .result_o    (result_o)
  );

endmodule
